// ----- hdl/dpss_pkg.sv -----
// ----------------------------------------------------------------------------
// Delayed power switch sequencer package
// Shared widths, mode codes, register indexes, op codes and the result flag type.
// ----------------------------------------------------------------------------
package dpss_pkg;

  localparam int TIME_BITS = 24;
  localparam int CFG_W     = 24;
  localparam int CMP_W     = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
  localparam int MODE_W    = 3;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  localparam logic [MODE_W-1:0] MODE_OFF      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PEND_ON  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_WAIT_ON  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ON       = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PEND_OFF = 3'd4;
  localparam logic [MODE_W-1:0] MODE_WAIT_OFF = 3'd5;

  localparam logic [1:0] REG_DELAY_BEFORE_OFF = 2'd0;
  localparam logic [1:0] REG_SETTLE_AFTER_ON  = 2'd1;
  localparam logic [1:0] REG_SETTLE_AFTER_OFF = 2'd2;

  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  typedef struct packed {
    logic send_on;
    logic send_off;
    logic changed;
    logic activity_start;
    logic activity_finish;
  } dpss_flags_t;

endpackage

// ----- hdl/dpss_core.sv -----
// ----------------------------------------------------------------------------
// Delayed power switch sequencer next-state logic
// Works out the next mode, elapsed count and result flags for one beat.
// ----------------------------------------------------------------------------
module dpss_core (
  input  logic                           op,
  input  logic                           target_on,
  input  logic [dpss_pkg::MODE_W-1:0]    mode,
  input  logic [dpss_pkg::TIME_BITS-1:0] elapsed,
  input  logic [dpss_pkg::CFG_W-1:0]     delay_before_off,
  input  logic [dpss_pkg::CFG_W-1:0]     settle_after_on,
  input  logic [dpss_pkg::CFG_W-1:0]     settle_after_off,
  output logic [dpss_pkg::MODE_W-1:0]    mode_nxt,
  output logic [dpss_pkg::TIME_BITS-1:0] elapsed_nxt,
  output dpss_pkg::dpss_flags_t          flags
);
  import dpss_pkg::*;

  logic [TIME_BITS-1:0] elapsed_inc;
  logic [CMP_W-1:0]     elapsed_ext;
  logic                 reach_on;
  logic                 reach_pend_off;
  logic                 reach_off;

  assign elapsed_inc    = (&elapsed) ? elapsed : elapsed + 1'b1;
  assign elapsed_ext    = CMP_W'(elapsed_inc);
  assign reach_on       = elapsed_ext >= CMP_W'(settle_after_on);
  assign reach_pend_off = elapsed_ext >= CMP_W'(delay_before_off);
  assign reach_off      = elapsed_ext >= CMP_W'(settle_after_off);

  always_comb begin
    mode_nxt    = mode;
    elapsed_nxt = elapsed;
    flags       = '0;
    if (op == OP_REQUEST) begin
      if (target_on) begin
        if (mode == MODE_OFF || mode == MODE_WAIT_OFF) begin
          mode_nxt = MODE_PEND_ON;
        end else if (mode == MODE_PEND_OFF) begin
          mode_nxt = MODE_ON;
        end
      end else begin
        if (mode == MODE_WAIT_ON || mode == MODE_ON) begin
          mode_nxt    = MODE_PEND_OFF;
          elapsed_nxt = '0;
        end else if (mode == MODE_PEND_ON) begin
          mode_nxt = MODE_OFF;
        end
      end
    end else begin
      elapsed_nxt = elapsed_inc;
      case (mode)
        MODE_PEND_ON: begin
          mode_nxt             = MODE_WAIT_ON;
          elapsed_nxt          = '0;
          flags.send_on        = 1'b1;
          flags.activity_start = 1'b1;
          flags.changed        = 1'b1;
        end
        MODE_WAIT_ON: begin
          if (reach_on) begin
            mode_nxt              = MODE_ON;
            flags.activity_finish = 1'b1;
            flags.changed         = 1'b1;
          end
        end
        MODE_PEND_OFF: begin
          if (reach_pend_off) begin
            mode_nxt             = MODE_WAIT_OFF;
            elapsed_nxt          = '0;
            flags.send_off       = 1'b1;
            flags.activity_start = 1'b1;
            flags.changed        = 1'b1;
          end
        end
        MODE_WAIT_OFF: begin
          if (reach_off) begin
            mode_nxt              = MODE_OFF;
            elapsed_nxt           = '0;
            flags.activity_finish = 1'b1;
            flags.changed         = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- hdl/delayed_power_switch_sequencer.sv -----
// ----------------------------------------------------------------------------
// Delayed power switch sequencer
// Sequences one device between off and on with timed waits.
// ----------------------------------------------------------------------------
// Each input beat (a tick or a switch request) yields exactly one result beat,
// in the cycle after it is accepted. A new beat is accepted in every cycle in
// which the result register is empty or is being drained; the mode and elapsed
// counter are registered with the result, giving one beat per cycle unless the
// result stalls. The user must write the three timing registers over the APB
// port at byte addresses 0, 4 and 8 only while idle; the block does not enforce it.
module delayed_power_switch_sequencer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dpss_pkg::ADDR_W-1:0]   paddr,
  input  logic [dpss_pkg::DATA_W-1:0]   pwdata,
  output logic [dpss_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_op,
  input  logic                          in_target_on,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dpss_pkg::MODE_W-1:0]   out_mode,
  output logic                          out_send_on,
  output logic                          out_send_off,
  output logic                          out_changed,
  output logic                          out_activity_start,
  output logic                          out_activity_finish
);
  import dpss_pkg::*;

  logic [CFG_W-1:0]     delay_before_off_r;
  logic [CFG_W-1:0]     settle_after_on_r;
  logic [CFG_W-1:0]     settle_after_off_r;
  logic [MODE_W-1:0]    mode_r;
  logic [MODE_W-1:0]    mode_nxt;
  logic [TIME_BITS-1:0] elapsed_r;
  logic [TIME_BITS-1:0] elapsed_nxt;
  dpss_flags_t          flags_nxt;
  dpss_flags_t          flags_r;
  logic                 out_valid_r;
  logic                 in_accept;
  logic                 cfg_write;
  logic [1:0]           reg_idx;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      REG_DELAY_BEFORE_OFF: prdata = DATA_W'(delay_before_off_r);
      REG_SETTLE_AFTER_ON:  prdata = DATA_W'(settle_after_on_r);
      REG_SETTLE_AFTER_OFF: prdata = DATA_W'(settle_after_off_r);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_before_off_r <= '0;
      settle_after_on_r  <= '0;
      settle_after_off_r <= '0;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_DELAY_BEFORE_OFF: delay_before_off_r <= pwdata[CFG_W-1:0];
        REG_SETTLE_AFTER_ON:  settle_after_on_r  <= pwdata[CFG_W-1:0];
        REG_SETTLE_AFTER_OFF: settle_after_off_r <= pwdata[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  dpss_core u_core (
    .op               (in_op),
    .target_on        (in_target_on),
    .mode             (mode_r),
    .elapsed          (elapsed_r),
    .delay_before_off (delay_before_off_r),
    .settle_after_on  (settle_after_on_r),
    .settle_after_off (settle_after_off_r),
    .mode_nxt         (mode_nxt),
    .elapsed_nxt      (elapsed_nxt),
    .flags            (flags_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_OFF;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        mode_r      <= mode_nxt;
        elapsed_r   <= elapsed_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      flags_r <= flags_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_mode            = mode_r;
  assign out_send_on         = flags_r.send_on;
  assign out_send_off        = flags_r.send_off;
  assign out_changed         = flags_r.changed;
  assign out_activity_start  = flags_r.activity_start;
  assign out_activity_finish = flags_r.activity_finish;

endmodule

// ----- hdl/dpss_chk.sv -----
// ----------------------------------------------------------------------------
// Delayed power switch sequencer checker
// Port-level assertions on result beats, bound to the top level.
// ----------------------------------------------------------------------------
module dpss_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [dpss_pkg::MODE_W-1:0] out_mode,
  input logic                        out_send_on,
  input logic                        out_send_off,
  input logic                        out_changed,
  input logic                        out_activity_start,
  input logic                        out_activity_finish
);
  import dpss_pkg::*;

  a_on_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_send_on |->
      out_mode == MODE_WAIT_ON && out_activity_start && out_changed && !out_send_off)
    else $error("on command without entering the on wait");

  a_off_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_send_off |->
      out_mode == MODE_WAIT_OFF && out_activity_start && out_changed)
    else $error("off command without entering the off wait");

  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_activity_finish |->
      (out_mode == MODE_ON || out_mode == MODE_OFF) && out_changed && !out_activity_start)
    else $error("activity finished outside a settled mode");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && out_valid && out_stall |=>
      out_valid && $stable(out_mode) && $stable(out_changed))
    else $error("stalled result beat changed");

endmodule

bind delayed_power_switch_sequencer dpss_chk u_dpss_chk (.*);
